// ===== sv/dfiir_pkg.sv =====
// Shared types and codes for the direct-form I IIR filter unit.
package dfiir_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int CNT_CFG_W = 11;
  localparam int CIDX_W   = 10;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  // Request function codes
  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_FF_COEF = 2'd1;
  localparam logic [1:0] FUNC_FB_COEF = 2'd2;

  // Configuration register indexes
  localparam logic REG_NUM_ZEROS = 1'b0;
  localparam logic REG_NUM_POLES = 1'b1;

  // Input request payload
  typedef struct packed {
    logic [1:0]                 func;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  // Result payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_t;

  // Sequencer to MAC controls
  typedef struct packed {
    logic start;  // load the accumulator with the rounding offset
    logic valid;  // coefficient and history operands are present
  } mac_ctl_t;

  // MAC status back to the sequencer
  typedef struct packed {
    logic busy;   // a product is still in flight
  } mac_st_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_WB
  } state_t;

endpackage

// ===== sv/dfiir_mac.sv =====
// Multiply-accumulate datapath with rounding and saturation to Q1.23.
module dfiir_mac
  import dfiir_pkg::*;
#(
  parameter int ACC_W = 68
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_W-1:0] hist,
  output out_t                       res,
  output mac_st_t                    st
);

  localparam int FRAC_SH = 24;
  localparam int TOP_LO  = FRAC_SH + SAMPLE_W - 1;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:TOP_LO]    acc_top;
  logic                     fits;

  // Product register, one stage ahead of the accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= coef * hist;
    end
  end

  // Accumulate; start preloads half an output LSB so the end value is rounded
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= ACC_W'(1) <<< (FRAC_SH - 1);
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Saturate when the output sign bit and the bits above it do not all match
  assign acc_top = acc_r[ACC_W-1:TOP_LO];
  assign fits    = (&acc_top) || !(|acc_top);

  always_comb begin
    res.saturated = !fits;
    if (fits) begin
      res.sample_out = acc_r[TOP_LO:FRAC_SH];
    end else if (acc_r[ACC_W-1]) begin
      res.sample_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res.sample_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign st.busy = prod_v_r;

endmodule

// ===== sv/direct_form_iir_filter_unit.sv =====
// Direct-form I IIR filter: sequencer, history and coefficient memories.
//
//  channel  | ports                          | accepted when
//  ---------+--------------------------------+-------------------------
//  request  | in_valid, in_stall, in_data    | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data | out_valid && !out_stall
//  config   | cfg_we, cfg_index, cfg_data    | cfg_we
//
// A sample request walks num_zeros feedforward and num_poles - 1 feedback taps
// (effective counts) through the single read port of each memory: one tap is
// fetched per cycle. Coefficient writes give no result.
// After reset all 2*2^clog2(MAX_TAPS) entries of each memory are cleared
// (2048 at the default), during which in_stall stays high.
// The result register frees the input side: a new request is taken while a
// result waits; the finished sample then holds until out_stall drops.
module direct_form_iir_filter_unit
  import dfiir_pkg::*;
#(
  parameter int MAX_TAPS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CNT_CFG_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = AW + 1;
  localparam int MEM_D = 2 ** (AW + 1);
  localparam int NW    = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
  localparam int XW    = (CW > CIDX_W) ? CW : CIDX_W;
  localparam int ACC_W = PROD_W + AW + 2;

  state_t state_r, state_nxt;

  logic [CNT_CFG_W-1:0] nz_r, np_r;
  logic [AW-1:0]        in_pos_r, in_pos_nxt;
  logic [AW-1:0]        out_pos_r, out_pos_nxt;
  logic [AW:0]          clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        ta_r, ta_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic                 out_valid_r;
  out_t                 out_data_r;

  // Memories: lower half feedforward / input side, upper half feedback / output
  logic [SAMPLE_W-1:0] hist_mem [0:MEM_D-1];
  logic [COEF_W-1:0]   coef_mem [0:MEM_D-1];
  logic [SAMPLE_W-1:0] hist_rd_r;
  logic [COEF_W-1:0]   coef_rd_r;

  logic                hist_we, coef_we;
  logic [AW:0]         hist_wa, coef_wa, hist_ra, coef_ra;
  logic [SAMPLE_W-1:0] hist_wd;
  logic [COEF_W-1:0]   coef_wd;

  logic                in_acc, out_load;
  mac_ctl_t            mac_ctl;
  mac_st_t             mac_st;
  out_t                mac_res;

  logic [NW-1:0]  nz_w, np_w, nz_lim, np_lim;
  logic [CW-1:0]  nz_eff, np_eff, nz_m1, np_m1;
  logic [AW-1:0]  ip_eff, op_eff;
  logic [CW-1:0]  ip_inc, op_inc;
  logic [XW-1:0]  cidx_w;
  logic           cidx_ok;
  logic [AW-1:0]  cidx;

  // Effective tap counts: zero acts as one, large values clip to MAX_TAPS
  assign nz_w   = NW'(nz_r);
  assign np_w   = NW'(np_r);
  assign nz_lim = (nz_w == '0) ? NW'(1) : (nz_w > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : nz_w;
  assign np_lim = (np_w == '0) ? NW'(1) : (np_w > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : np_w;
  assign nz_eff = nz_lim[CW-1:0];
  assign np_eff = np_lim[CW-1:0];
  assign nz_m1  = nz_eff - 1'b1;
  assign np_m1  = np_eff - 1'b1;

  // Positions restart at zero once the count has shrunk to or below them
  assign ip_eff = ({1'b0, in_pos_r} < nz_eff) ? in_pos_r : '0;
  assign op_eff = ({1'b0, out_pos_r} < np_eff) ? out_pos_r : '0;
  assign ip_inc = {1'b0, ip_eff} + 1'b1;
  assign op_inc = {1'b0, op_eff} + 1'b1;

  // Coefficient address check
  assign cidx_w  = XW'(in_data.coef_index);
  assign cidx_ok = cidx_w < XW'(MAX_TAPS);
  assign cidx    = cidx_w[AW-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r <= CNT_CFG_W'(1);
      np_r <= CNT_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ZEROS: nz_r <= cfg_data;
        REG_NUM_POLES: np_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      in_pos_r   <= '0;
      out_pos_r  <= '0;
      k_r        <= '0;
      ta_r       <= '0;
      rd_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      in_pos_r   <= in_pos_nxt;
      out_pos_r  <= out_pos_nxt;
      k_r        <= k_nxt;
      ta_r       <= ta_nxt;
      rd_v_r     <= rd_v_nxt;
    end
  end

  // Next state, memory ports and MAC controls
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    in_pos_nxt   = in_pos_r;
    out_pos_nxt  = out_pos_r;
    k_nxt        = k_r;
    ta_nxt       = ta_r;
    rd_v_nxt     = 1'b0;
    hist_we      = 1'b0;
    hist_wa      = '0;
    hist_wd      = '0;
    coef_we      = 1'b0;
    coef_wa      = '0;
    coef_wd      = '0;
    hist_ra      = '0;
    coef_ra      = '0;
    mac_ctl      = '0;
    out_load     = 1'b0;
    mac_ctl.valid = rd_v_r;

    case (state_r)
      ST_CLEAR: begin
        // Zero one entry of each memory per cycle
        hist_we      = 1'b1;
        hist_wa      = clr_addr_r;
        coef_we      = 1'b1;
        coef_wa      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            FUNC_SAMPLE: begin
              // Store the new sample, then walk the feedforward taps
              hist_we       = 1'b1;
              hist_wa       = {1'b0, ip_eff};
              hist_wd       = in_data.sample_in;
              mac_ctl.start = 1'b1;
              k_nxt         = '0;
              ta_nxt        = ip_eff;
              state_nxt     = ST_FF;
            end
            FUNC_FF_COEF: begin
              coef_we = cidx_ok;
              coef_wa = {1'b0, cidx};
              coef_wd = in_data.coef_value;
            end
            FUNC_FB_COEF: begin
              coef_we = cidx_ok;
              coef_wa = {1'b1, cidx};
              coef_wd = in_data.coef_value;
            end
            default: ;
          endcase
        end
      end

      ST_FF: begin
        hist_ra  = {1'b0, ta_r};
        coef_ra  = {1'b0, k_r};
        rd_v_nxt = 1'b1;
        if ({1'b0, k_r} == nz_m1) begin
          if (np_eff > CW'(1)) begin
            k_nxt     = AW'(1);
            ta_nxt    = (op_eff == '0) ? np_m1[AW-1:0] : op_eff - 1'b1;
            state_nxt = ST_FB;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          k_nxt  = k_r + 1'b1;
          ta_nxt = (ta_r == '0) ? nz_m1[AW-1:0] : ta_r - 1'b1;
        end
      end

      ST_FB: begin
        hist_ra  = {1'b1, ta_r};
        coef_ra  = {1'b1, k_r};
        rd_v_nxt = 1'b1;
        if ({1'b0, k_r} == np_m1) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt  = k_r + 1'b1;
          ta_nxt = (ta_r == '0) ? np_m1[AW-1:0] : ta_r - 1'b1;
        end
      end

      ST_DRAIN: begin
        // Wait for the last product to land in the accumulator
        if (!rd_v_r && !mac_st.busy) begin
          state_nxt = ST_WB;
        end
      end

      ST_WB: begin
        // Hold until the result register is free, then record the output
        if (!out_valid_r || !out_stall) begin
          out_load    = 1'b1;
          hist_we     = 1'b1;
          hist_wa     = {1'b1, op_eff};
          hist_wd     = mac_res.sample_out;
          in_pos_nxt  = (ip_inc >= nz_eff) ? '0 : ip_inc[AW-1:0];
          out_pos_nxt = (op_inc >= np_eff) ? '0 : op_inc[AW-1:0];
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // History memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[coef_ra];
  end

  dfiir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  ($signed(coef_rd_r)),
    .hist  ($signed(hist_rd_r)),
    .res   (mac_res),
    .st    (mac_st)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Tap reads come only from the feedforward or feedback walk
  a_rd_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == ST_FF || $past(state_r) == ST_FB))
    else $error("history read outside the tap walk");

  // The result is taken from the accumulator only once the pipeline is empty
  a_wb_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (!rd_v_r && !mac_st.busy))
    else $error("write-back with products still in flight");

  // Leaving write-back always leaves a result waiting
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && $past(state_r) == ST_WB) |-> out_valid_r)
    else $error("sample finished without a result");
`endif

endmodule
